// ===== sv/cil_pkg.sv =====
// cil_pkg: shared constants, operation and status codes for the circular
// indexed list core. No dependencies; compile first.

package cil_pkg;

  // Storage sizing
  localparam int DEPTH      = 64;
  localparam int INDEX_BITS = 16;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths of the transactions
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 16;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  // Low INDEX_BITS bits of the index take part in the modulo
  localparam logic [INDEX_W-1:0] IDX_MASK =
    (INDEX_BITS >= INDEX_W) ? {INDEX_W{1'b1}} :
    INDEX_W'((64'd1 << INDEX_BITS) - 64'd1);

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_GET    = 2'd0;
  localparam logic [FUNC_W-1:0] OP_SET    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd2;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ===== sv/cil_ifs.sv =====
// cil_ifs: valid/ready channel interfaces for the request and result
// transactions of the circular indexed list core. Depends on cil_pkg.

interface cil_in_if;
  import cil_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [INDEX_W-1:0]  index;
  data_t               value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface cil_out_if;
  import cil_pkg::*;
  logic                valid;
  logic                ready;
  data_t               read_value;
  logic [LEN_W-1:0]    length;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output read_value, output length, output status,
                  input ready);
  modport sink   (input valid, input read_value, input length, input status,
                  output ready);
endinterface

// ===== sv/cil_mod_unit.sv =====
// cil_mod_unit: bit-serial restoring remainder unit, one quotient bit per
// cycle through a single compare/subtract. Depends on cil_pkg.

module cil_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cil_pkg::INDEX_W-1:0]  dividend,
  input  logic [cil_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [cil_pkg::CNT_W-1:0]    remainder
);
  import cil_pkg::*;

  localparam int STEP_W = $clog2(INDEX_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [INDEX_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [CNT_W:0]      trial;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[INDEX_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[INDEX_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(INDEX_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== sv/circular_indexed_list_core.sv =====
// circular_indexed_list_core: top level of the indexed list. Holds the entry
// memory and the sequencer. Depends on cil_pkg, cil_ifs and cil_mod_unit.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid / ready    | func, index, value
//   out_ch   | out | valid / ready    | read_value, length, status
//
// An append and every empty or full case go straight to the finish step.
// Set, get and remove first run the bit-serial modulo of the index by the
// length; remove then moves each following element down one place, with a
// read and then a write through the single memory port per element. One
// transaction is in work at a time; a result waits in the output register
// while the next request is taken, and the finish step stalls while that
// register is still occupied. Reset empties the list; entry contents stay
// undefined until written.

module circular_indexed_list_core (
  input  logic      clk,
  input  logic      rst_n,
  cil_in_if.sink    in_ch,
  cil_out_if.source out_ch
);
  import cil_pkg::*;

  localparam int SW = 3;
  localparam logic [SW-1:0] S_IDLE  = 3'd0;
  localparam logic [SW-1:0] S_MOD   = 3'd1;
  localparam logic [SW-1:0] S_GETRD = 3'd2;
  localparam logic [SW-1:0] S_GETW  = 3'd3;
  localparam logic [SW-1:0] S_SHRD  = 3'd4;
  localparam logic [SW-1:0] S_SHWR  = 3'd5;
  localparam logic [SW-1:0] S_FIN   = 3'd6;

  logic [SW-1:0]       state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  data_t               value_r, value_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  data_t               res_val_r, res_val_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;

  logic                out_valid_r, out_valid_nxt;
  data_t               out_val_r, out_val_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  // Entry memory: one port, registered read
  data_t               entries_r [DEPTH];
  data_t               rdata_r;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  data_t               mem_wdata;

  logic                mod_start, mod_done;
  logic [CNT_W-1:0]    mod_rem;
  logic                in_fire, out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  cil_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_ch.index & IDX_MASK),
    .divisor   (count_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    func_nxt    = func_r;
    value_nxt   = value_r;
    ptr_nxt     = ptr_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    mod_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ptr_r;
    mem_raddr   = ptr_r;
    mem_wdata   = value_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt    = in_ch.func;
          value_nxt   = in_ch.value;
          res_val_nxt = '0;
          res_st_nxt  = ST_DONE;
          state_nxt   = S_FIN;
          if (in_ch.func == OP_PUSH) begin
            if (count_r >= CNT_W'(DEPTH)) begin
              res_st_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(count_r);
              mem_wdata = in_ch.value;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            res_st_nxt = ST_EMPTY;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          ptr_nxt = ADDR_W'(mod_rem);
          unique case (func_r)
            OP_GET:    state_nxt = S_GETRD;
            OP_SET: begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(mod_rem);
              state_nxt = S_FIN;
            end
            default:   state_nxt = S_SHRD;
          endcase
        end
      end
      S_GETRD: begin
        mem_re    = 1'b1;
        state_nxt = S_GETW;
      end
      S_GETW: begin
        res_val_nxt = rdata_r;
        state_nxt   = S_FIN;
      end
      // Move the following element down one place, or finish the remove
      S_SHRD: begin
        if ((CNT_W'(ptr_r) + 1'b1) < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r + 1'b1;
          state_nxt = S_SHWR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_SHRD;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: load on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_len_nxt   = out_len_r;
    out_st_nxt    = out_st_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FIN && out_free) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_len_nxt   = LEN_W'(count_r);
      out_st_nxt    = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    value_r   <= value_nxt;
    ptr_r     <= ptr_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_len_r <= out_len_nxt;
    out_st_r  <= out_st_nxt;
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= entries_r[mem_raddr];
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_val_r;
  assign out_ch.length     = out_len_r;
  assign out_ch.status     = out_st_r;

endmodule
